FILE: hw/rtl/nprime_pkg.sv
// Shared constants and handshake types for the next prime table size block.
package nprime_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivW  = 17;
  localparam int unsigned SqW   = 34;

  localparam logic [DataW-1:0] MinPrime = 32'd31;
  localparam logic [DataW-1:0] MaxPrime = 32'd4294967279;

  localparam logic [DivW-1:0] FirstDiv = 17'd3;
  localparam logic [SqW-1:0]  FirstSq  = 34'd9;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } mod_rsp_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StKick = 4'b0010,
    StWait = 4'b0100,
    StOut  = 4'b1000
  } np_state_e;

endpackage

FILE: hw/rtl/next_prime_table_size_core.sv
// Top level: sequencer for the prime table size search over a single remainder unit.
//
//   channel   signals                      direction  handshake
//   command   start, busy, size_hint_i     in         taken when start && !busy
//   result    done_o, table_size_o         out        one-cycle strobe on done_o
//
// A clamped hint answers in the cycle right after it is taken.
// Each trial divisor is launched in StKick, run through the bit-serial
// remainder unit and decided in StWait; a candidate costs up to about
// 32768 divisors, repeated over every candidate of the prime gap.
// busy stays high from the cycle after an item is taken until its result
// strobe; reset clears the sequencer and the remainder unit's control.
// The receiver cannot stall: the result is shown for exactly one cycle.
module next_prime_table_size_core import nprime_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [DataW-1:0] size_hint_i,
  output logic             done_o,
  output logic [DataW-1:0] table_size_o
);

  np_state_e        state_q, state_d;
  logic [DataW-1:0] cand_q, cand_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [DataW-1:0] res_q, res_d;
  logic [DivW-1:0]  div_inc;
  mod_req_t         mod_req;
  mod_rsp_t         mod_rsp;
  logic             accept;

  assign accept  = start && !busy;
  assign div_inc = div_q + 17'd1;

  nprime_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign mod_req.start    = (state_q == StKick);
  assign mod_req.dividend = cand_q;
  assign mod_req.divisor  = div_q;

  always_comb begin
    state_d = state_q;
    cand_d  = cand_q;
    div_d   = div_q;
    sq_d    = sq_q;
    res_d   = res_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (size_hint_i <= MinPrime) begin
            res_d   = MinPrime;
            state_d = StOut;
          end else if (size_hint_i >= MaxPrime) begin
            res_d   = MaxPrime;
            state_d = StOut;
          end else begin
            cand_d  = size_hint_i | 32'd1;
            div_d   = FirstDiv;
            sq_d    = FirstSq;
            state_d = StKick;
          end
        end
      end
      StKick: begin
        state_d = StWait;
      end
      StWait: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem == '0) begin
            if (cand_q < MaxPrime) begin
              cand_d  = cand_q + 32'd2;
              div_d   = FirstDiv;
              sq_d    = FirstSq;
              state_d = StKick;
            end else begin
              res_d   = cand_q;
              state_d = StOut;
            end
          end else if (sq_q >= {2'b00, cand_q}) begin
            res_d   = cand_q;
            state_d = StOut;
          end else begin
            div_d   = div_q + 17'd2;
            sq_d    = sq_q + {15'd0, div_inc, 2'b00};
            state_d = StKick;
          end
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    div_q  <= div_d;
    sq_q   <= sq_d;
    res_q  <= res_d;
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = (state_q == StOut);
  assign table_size_o = res_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("item taken but block not busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (table_size_o >= MinPrime && table_size_o <= MaxPrime))
    else $error("result outside table size range");

  a_done_rem_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == StWait))
    else $error("remainder returned outside wait state");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StKick) |-> (div_q[0] && div_q >= FirstDiv))
    else $error("trial divisor not odd");

endmodule

FILE: hw/rtl/nprime_mod_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module nprime_mod_unit import nprime_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic [DataW-1:0] dvd_q;
  logic [DivW-1:0]  dvs_q;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [4:0]       cnt_q;
  logic             run_q;
  logic             done_q;
  logic [DivW:0]    trial;
  logic [DivW:0]    diff;

  assign trial = {rem_q, dvd_q[DataW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[DivW-1:0];
    end else begin
      rem_d = trial[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= '0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DataW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("remainder not below divisor");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(run_q))
    else $error("done without a run");

  a_no_run_and_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && done_q))
    else $error("run and done together");

endmodule
